// ----- rtl/fes_pkg.sv -----
// Package for the face expression and blink sequencer.
// Holds field widths, reset values, operation and phase codes, and the
// command and status structs shared by the controller and the datapath.
`default_nettype none

package fes_pkg;

  // Field widths of the channels and registers.
  localparam int OP_W       = 3;
  localparam int EXPR_W     = 4;
  localparam int BOOP_W     = 16;
  localparam int DT_W       = 10;
  localparam int DRAW_W     = 14;
  localparam int WEIGHT_W   = 17;
  localparam int PHASE_W    = 2;
  localparam int COUNT_W    = 5;
  localparam int FADE_W     = 14;
  localparam int BDUR_W     = 11;
  localparam int IVAL_W     = 16;
  localparam int EYE_T_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Expression count limits.
  localparam int MAX_EXPRESSIONS = 16;
  localparam int EXPR_CAP        = (MAX_EXPRESSIONS < 16) ? MAX_EXPRESSIONS : 16;

  // Q16 weights and timing constants.
  localparam int                  Q16_SHIFT = 16;
  localparam logic [WEIGHT_W-1:0] Q16_ONE   = WEIGHT_W'(65536);
  localparam logic [EYE_T_W-1:0]  HOLD_MS   = EYE_T_W'(40);
  localparam logic [DRAW_W-1:0]   DRAW_SPAN = DRAW_W'(10000);
  localparam logic [FADE_W-1:0]   FADE_MIN  = FADE_W'(10);
  // A ramp that has not finished has 2*t below the duration, so t fits here.
  localparam int                  RAMP_T_W  = BDUR_W - 1;

  // Register reset values.
  localparam logic [COUNT_W-1:0] CFG_COUNT_RST = COUNT_W'(8);
  localparam logic [FADE_W-1:0]  CFG_FADE_RST  = FADE_W'(250);
  localparam logic [BDUR_W-1:0]  CFG_BDUR_RST  = BDUR_W'(150);
  localparam logic [IVAL_W-1:0]  CFG_MIN_RST   = IVAL_W'(2000);
  localparam logic [IVAL_W-1:0]  CFG_MAX_RST   = IVAL_W'(6000);
  localparam logic [IVAL_W-1:0]  COUNTDOWN_RST = IVAL_W'(2000);

  // Shared serial divider: two quotient bits per cycle.
  localparam int DIV_NUM_W   = 30;
  localparam int DIV_DEN_W   = 14;
  localparam int DIV_RADIX_B = 2;
  localparam int DIV_STEPS   = DIV_NUM_W / DIV_RADIX_B;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_SET   = 3'd1,
    OP_NEXT  = 3'd2,
    OP_PREV  = 3'd3,
    OP_BOOP  = 3'd4,
    OP_BLINK = 3'd5
  } fes_op_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_OPEN    = 2'd0,
    PH_CLOSING = 2'd1,
    PH_HOLD    = 2'd2,
    PH_OPENING = 2'd3
  } fes_phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPR_COUNT = 3'd0,
    CFG_FADE_MS    = 3'd1,
    CFG_BLINK_DUR  = 3'd2,
    CFG_IVAL_MIN   = 3'd3,
    CFG_IVAL_MAX   = 3'd4
  } fes_cfg_idx_t;

  typedef enum logic [1:0] {
    DSEL_FADE = 2'd0,
    DSEL_NAV  = 2'd1,
    DSEL_RAMP = 2'd2,
    DSEL_DRAW = 2'd3
  } fes_div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE      = 4'd0,
    S_DECODE    = 4'd1,
    S_EXEC      = 4'd2,
    S_NAV_WAIT  = 4'd3,
    S_FADE_WAIT = 4'd4,
    S_BOOP      = 4'd5,
    S_EYE       = 4'd6,
    S_EYE_DIV   = 4'd7,
    S_EYE_WAIT  = 4'd8,
    S_DONE      = 4'd9
  } fes_state_t;

  typedef struct packed {
    logic         load_item;
    logic         exec_op;
    logic         fade_apply;
    logic         boop_apply;
    logic         eye_step;
    logic         eye_apply;
    logic         out_load;
    logic         div_start;
    fes_div_sel_t div_sel;
  } fes_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            fade_busy;
    logic            need_ramp;
    logic            need_draw;
  } fes_stat_t;

endpackage

`default_nettype wire

// ----- rtl/fes_if.sv -----
// Channel interfaces of the face expression and blink sequencer:
// event input, status result and register write port.
// Depends on fes_pkg for the field widths.
`default_nettype none

interface fes_in_if
  import fes_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [EXPR_W-1:0]   expression_index;
  logic [BOOP_W-1:0]   boop_duration_ms;
  logic [DT_W-1:0]     elapsed_ms;
  logic [DRAW_W-1:0]   random_draw;

  modport source (output valid, operation, expression_index, boop_duration_ms,
                  elapsed_ms, random_draw, input ready);
  modport sink   (input valid, operation, expression_index, boop_duration_ms,
                  elapsed_ms, random_draw, output ready);
endinterface

interface fes_out_if
  import fes_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [EXPR_W-1:0]   current_expression;
  logic [EXPR_W-1:0]   previous_expression;
  logic [WEIGHT_W-1:0] transition_weight;
  logic [PHASE_W-1:0]  blink_phase_out;
  logic [WEIGHT_W-1:0] blink_weight_out;
  logic                boop_active;

  modport source (output valid, current_expression, previous_expression,
                  transition_weight, blink_phase_out, blink_weight_out,
                  boop_active, input ready);
  modport sink   (input valid, current_expression, previous_expression,
                  transition_weight, blink_phase_out, blink_weight_out,
                  boop_active, output ready);
endinterface

interface fes_cfg_if
  import fes_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/face_expression_blink_sequencer.sv -----
// Face expression and blink sequencer, top level. Depends on fes_pkg,
// fes_if, fes_div, fes_ctrl and fes_dp.
//
// Events arrive on in_if (valid/ready); each accepted transfer produces exactly
// one status transfer on out_if, in order. An event sets, steps or boops the
// expression, starts a blink, or is a tick that advances the fade, the boop
// countdown and the four-phase eyelid machine by elapsed_ms milliseconds.
// Registers are written on cfg_if, which is always ready; write them only while
// the block is idle. Unknown register indexes are ignored.
//
// One event is worked on at a time, so a new event is taken only once the
// current one has reached its result. The pace is set by the single shared
// divider, which yields two quotient bits a cycle: set, boop, blink and
// undefined codes use no divide, next/previous use one for the wrap, and a
// tick uses up to two, one for the fade step and one for the eyelid ramp or
// the next blink interval.
// A stalled receiver holds the result in the output register; the next event is
// still accepted and worked on, and waits only for that register to free up.
// Synchronous active-low reset restores configuration, event and control state.
`default_nettype none

module face_expression_blink_sequencer
  import fes_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  fes_in_if.sink    in_if,
  fes_out_if.source out_if,
  fes_cfg_if.sink   cfg_if
);

  fes_cmd_t             cmd;
  fes_stat_t            stat;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [DIV_DEN_W-1:0] div_rem;

  // Register writes never stall.
  assign cfg_if.ready = 1'b1;

  fes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (stat),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  fes_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_if.valid),
    .cfg_idx             (cfg_if.index),
    .cfg_data            (cfg_if.data),
    .operation           (in_if.operation),
    .expression_index    (in_if.expression_index),
    .boop_duration_ms    (in_if.boop_duration_ms),
    .elapsed_ms          (in_if.elapsed_ms),
    .random_draw         (in_if.random_draw),
    .cmd                 (cmd),
    .div_quo             (div_quo),
    .div_rem             (div_rem),
    .div_num             (div_num),
    .div_den             (div_den),
    .stat                (stat),
    .current_expression  (out_if.current_expression),
    .previous_expression (out_if.previous_expression),
    .transition_weight   (out_if.transition_weight),
    .blink_phase_out     (out_if.blink_phase_out),
    .blink_weight_out    (out_if.blink_weight_out),
    .boop_active         (out_if.boop_active)
  );

  fes_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Once a divide starts, the block is busy with the current event.
  a_div_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !in_if.ready)
    else $error("divider started while the block was taking events");

  // A divide never finishes while the block waits for a new event.
  a_div_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !in_if.ready)
    else $error("divider result arrived while the block was idle");

  // Reported weights stay within Q16 one.
  a_weights_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.transition_weight <= Q16_ONE) &&
                     (out_if.blink_weight_out <= Q16_ONE))
    else $error("reported weight above full scale");

  // Loading the result register raises valid.
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_if.valid)
    else $error("result register loaded without raising valid");

endmodule

`default_nettype wire

// ----- rtl/fes_div.sv -----
// Shared restoring divider, two quotient bits per cycle.
// Depends on fes_pkg for the operand widths and step count.
`default_nettype none

module fes_div
  import fes_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [DIV_NUM_W-1:0] num,
  input  wire logic [DIV_DEN_W-1:0] den,
  output logic                      done,
  output logic [DIV_NUM_W-1:0]      quo,
  output logic [DIV_DEN_W-1:0]      rem
);

  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   trial;

  // The numerator register shifts out dividend bits at the top and takes
  // quotient bits in at the bottom.
  always_comb begin
    rem_nxt = rem_r;
    num_nxt = num_r;
    trial   = '0;
    for (int i = 0; i < DIV_RADIX_B; i++) begin
      trial = {rem_nxt, num_nxt[DIV_NUM_W-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DIV_DEN_W'(trial - {1'b0, den_r});
        num_nxt = {num_nxt[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DEN_W-1:0];
        num_nxt = {num_nxt[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = num_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- rtl/fes_ctrl.sv -----
// Controller of the face expression and blink sequencer: sequences one
// event through decode, divides and state updates, and owns output valid.
// Depends on fes_pkg for the state, command and status types.
`default_nettype none

module fes_ctrl
  import fes_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire fes_stat_t stat,
  input  wire logic      div_done,
  output fes_cmd_t       cmd
);

  fes_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       is_nav;

  assign is_nav = (stat.op == OP_NEXT) || (stat.op == OP_PREV);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (stat.op == OP_TICK) begin
          state_nxt = stat.fade_busy ? S_FADE_WAIT : S_BOOP;
        end else if (is_nav) begin
          state_nxt = S_NAV_WAIT;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC:      state_nxt = S_DONE;
      S_NAV_WAIT: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_FADE_WAIT: begin
        if (div_done) state_nxt = S_BOOP;
      end
      S_BOOP:      state_nxt = S_EYE;
      S_EYE:       state_nxt = S_EYE_DIV;
      S_EYE_DIV: begin
        state_nxt = (stat.need_ramp || stat.need_draw) ? S_EYE_WAIT : S_DONE;
      end
      S_EYE_WAIT: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.div_sel = DSEL_FADE;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_DECODE: begin
        if (stat.op == OP_TICK) begin
          cmd.div_sel   = DSEL_FADE;
          cmd.div_start = stat.fade_busy;
        end else if (is_nav) begin
          cmd.div_sel   = DSEL_NAV;
          cmd.div_start = 1'b1;
        end
      end
      S_EXEC:      cmd.exec_op = 1'b1;
      S_NAV_WAIT: begin
        cmd.div_sel = DSEL_NAV;
        cmd.exec_op = div_done;
      end
      S_FADE_WAIT: cmd.fade_apply = div_done;
      S_BOOP:      cmd.boop_apply = 1'b1;
      S_EYE:       cmd.eye_step = 1'b1;
      S_EYE_DIV: begin
        cmd.div_sel   = stat.need_draw ? DSEL_DRAW : DSEL_RAMP;
        cmd.div_start = stat.need_ramp || stat.need_draw;
      end
      S_EYE_WAIT: begin
        cmd.div_sel   = stat.need_draw ? DSEL_DRAW : DSEL_RAMP;
        cmd.eye_apply = div_done;
      end
      S_DONE:      cmd.out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/fes_dp.sv -----
// Datapath of the face expression and blink sequencer: registers, event
// state, divider operand selection and the status result register.
// Depends on fes_pkg; driven by fes_ctrl commands, fed by fes_div results.
`default_nettype none

module fes_dp
  import fes_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [OP_W-1:0]       operation,
  input  wire logic [EXPR_W-1:0]     expression_index,
  input  wire logic [BOOP_W-1:0]     boop_duration_ms,
  input  wire logic [DT_W-1:0]       elapsed_ms,
  input  wire logic [DRAW_W-1:0]     random_draw,
  input  wire fes_cmd_t              cmd,
  input  wire logic [DIV_NUM_W-1:0]  div_quo,
  input  wire logic [DIV_DEN_W-1:0]  div_rem,
  output logic [DIV_NUM_W-1:0]       div_num,
  output logic [DIV_DEN_W-1:0]       div_den,
  output fes_stat_t                  stat,
  output logic [EXPR_W-1:0]          current_expression,
  output logic [EXPR_W-1:0]          previous_expression,
  output logic [WEIGHT_W-1:0]        transition_weight,
  output logic [PHASE_W-1:0]         blink_phase_out,
  output logic [WEIGHT_W-1:0]        blink_weight_out,
  output logic                       boop_active
);

  localparam int FADE_SUM_W = WEIGHT_W + 1;

  // Configuration registers.
  logic [COUNT_W-1:0] cfg_count_r;
  logic [FADE_W-1:0]  cfg_fade_r;
  logic [BDUR_W-1:0]  cfg_bdur_r;
  logic [IVAL_W-1:0]  cfg_min_r;
  logic [IVAL_W-1:0]  cfg_max_r;

  // Event state.
  logic [EXPR_W-1:0]   expr_now_r, expr_now_nxt;
  logic [EXPR_W-1:0]   expr_before_r, expr_before_nxt;
  logic [EXPR_W-1:0]   boop_ret_r, boop_ret_nxt;
  logic [WEIGHT_W-1:0] fade_r, fade_nxt;
  logic [BOOP_W-1:0]   boop_left_r, boop_left_nxt;
  fes_phase_t          phase_r, phase_nxt;
  logic [EYE_T_W-1:0]  eye_t_r, eye_t_nxt;
  logic [WEIGHT_W-1:0] eye_w_r, eye_w_nxt;
  logic [IVAL_W-1:0]   countdown_r, countdown_nxt;
  logic                need_ramp_r, need_ramp_nxt;
  logic                need_draw_r, need_draw_nxt;

  // Latched event fields and interval products.
  logic [OP_W-1:0]      op_r;
  logic [EXPR_W-1:0]    idx_r;
  logic [BOOP_W-1:0]    dur_r;
  logic [DT_W-1:0]      dt_r;
  logic [DRAW_W-1:0]    draw_r;
  logic [DIV_NUM_W-1:0] prod_lo_r;
  logic [DIV_NUM_W-1:0] prod_hi_r;

  // Result register.
  logic [EXPR_W-1:0]   out_cur_r;
  logic [EXPR_W-1:0]   out_prev_r;
  logic [WEIGHT_W-1:0] out_fade_r;
  logic [PHASE_W-1:0]  out_phase_r;
  logic [WEIGHT_W-1:0] out_eye_w_r;
  logic                out_boop_r;

  logic [COUNT_W-1:0]    n_eff;
  logic [FADE_W-1:0]     fade_div;
  logic [BDUR_W-1:0]     bdur_eff;
  logic [DRAW_W-1:0]     draw_c;
  logic [DRAW_W-1:0]     draw_rest;
  logic [COUNT_W-1:0]    nav_num;
  logic [EXPR_W-1:0]     tgt;
  logic                  set_ok;
  logic                  set_req;
  logic [FADE_SUM_W-1:0] fade_sum;
  logic                  fade_clamp;
  logic [EYE_T_W:0]      t_sum;
  logic [EYE_T_W-1:0]    t_adv;
  logic                  ramp_end;

  // Effective register values: zero count acts as one, short fades as the minimum.
  always_comb begin
    if (cfg_count_r == '0) begin
      n_eff = COUNT_W'(1);
    end else if (cfg_count_r > COUNT_W'(EXPR_CAP)) begin
      n_eff = COUNT_W'(EXPR_CAP);
    end else begin
      n_eff = cfg_count_r;
    end
    fade_div  = (cfg_fade_r < FADE_MIN) ? FADE_MIN : cfg_fade_r;
    bdur_eff  = (cfg_bdur_r == '0) ? BDUR_W'(1) : cfg_bdur_r;
    draw_c    = (draw_r > DRAW_SPAN) ? DRAW_SPAN : draw_r;
    draw_rest = DRAW_SPAN - draw_c;
  end

  // Divider operands. The blink interval is the weighted sum of the two bounds
  // divided by the draw span, which keeps it between them in either order.
  always_comb begin
    if (op_r == OP_NEXT) begin
      nav_num = {1'b0, expr_now_r} + COUNT_W'(1);
    end else begin
      nav_num = {1'b0, expr_now_r} + n_eff - COUNT_W'(1);
    end
    unique case (cmd.div_sel)
      DSEL_FADE: begin
        div_num = DIV_NUM_W'({dt_r, Q16_SHIFT'(0)});
        div_den = fade_div;
      end
      DSEL_NAV: begin
        div_num = DIV_NUM_W'(nav_num);
        div_den = DIV_DEN_W'(n_eff);
      end
      DSEL_RAMP: begin
        div_num = DIV_NUM_W'({eye_t_r[RAMP_T_W-1:0], (Q16_SHIFT + 1)'(0)});
        div_den = DIV_DEN_W'(bdur_eff);
      end
      DSEL_DRAW: begin
        div_num = prod_lo_r + prod_hi_r;
        div_den = DRAW_SPAN;
      end
      default: begin
        div_num = '0;
        div_den = DIV_DEN_W'(1);
      end
    endcase
  end

  // Expression change check, shared by set, next, previous, boop and boop restore.
  always_comb begin
    tgt = idx_r;
    if (cmd.boop_apply) begin
      tgt = boop_ret_r;
    end else if ((op_r == OP_NEXT) || (op_r == OP_PREV)) begin
      tgt = div_rem[EXPR_W-1:0];
    end
    set_ok = ({1'b0, tgt} < n_eff) && (tgt != expr_now_r);
  end

  always_comb begin
    fade_sum   = {1'b0, fade_r} + {1'b0, div_quo[WEIGHT_W-1:0]};
    fade_clamp = (|div_quo[DIV_NUM_W-1:WEIGHT_W]) || (fade_sum > FADE_SUM_W'(Q16_ONE));
    t_sum      = {1'b0, eye_t_r} + (EYE_T_W + 1)'(dt_r);
    t_adv      = t_sum[EYE_T_W] ? '1 : t_sum[EYE_T_W-1:0];
    ramp_end   = {t_adv, 1'b0} >= (EYE_T_W + 1)'(bdur_eff);
  end

  always_comb begin
    expr_now_nxt    = expr_now_r;
    expr_before_nxt = expr_before_r;
    boop_ret_nxt    = boop_ret_r;
    fade_nxt        = fade_r;
    boop_left_nxt   = boop_left_r;
    phase_nxt       = phase_r;
    eye_t_nxt       = eye_t_r;
    eye_w_nxt       = eye_w_r;
    countdown_nxt   = countdown_r;
    need_ramp_nxt   = need_ramp_r;
    need_draw_nxt   = need_draw_r;
    set_req         = 1'b0;

    if (cmd.exec_op) begin
      case (op_r) inside
        OP_SET, OP_NEXT, OP_PREV: set_req = 1'b1;
        OP_BOOP: begin
          if (boop_left_r == '0) boop_ret_nxt = expr_now_r;
          boop_left_nxt = dur_r;
          set_req       = 1'b1;
        end
        OP_BLINK: begin
          if (phase_r == PH_OPEN) begin
            phase_nxt = PH_CLOSING;
            eye_t_nxt = '0;
          end
        end
        default: ;
      endcase
    end

    if (cmd.fade_apply) begin
      fade_nxt = fade_clamp ? Q16_ONE : fade_sum[WEIGHT_W-1:0];
    end

    // A running boop counts down and restores the saved expression at zero.
    if (cmd.boop_apply && (boop_left_r != '0)) begin
      if (BOOP_W'(dt_r) >= boop_left_r) begin
        boop_left_nxt = '0;
        set_req       = 1'b1;
      end else begin
        boop_left_nxt = boop_left_r - BOOP_W'(dt_r);
      end
    end

    // Eyelid step; ramps still running ask for a divide, and so does a finished opening.
    if (cmd.eye_step) begin
      need_ramp_nxt = 1'b0;
      need_draw_nxt = 1'b0;
      unique case (phase_r)
        PH_OPEN: begin
          if (IVAL_W'(dt_r) >= countdown_r) begin
            countdown_nxt = '0;
            phase_nxt     = PH_CLOSING;
            eye_t_nxt     = '0;
          end else begin
            countdown_nxt = countdown_r - IVAL_W'(dt_r);
          end
        end
        PH_CLOSING: begin
          eye_t_nxt = t_adv;
          if (ramp_end) begin
            eye_w_nxt = Q16_ONE;
            phase_nxt = PH_HOLD;
            eye_t_nxt = '0;
          end else begin
            need_ramp_nxt = 1'b1;
          end
        end
        PH_HOLD: begin
          eye_t_nxt = t_adv;
          if (t_adv >= HOLD_MS) begin
            phase_nxt = PH_OPENING;
            eye_t_nxt = '0;
          end
        end
        PH_OPENING: begin
          eye_t_nxt = t_adv;
          if (ramp_end) begin
            eye_w_nxt     = '0;
            phase_nxt     = PH_OPEN;
            eye_t_nxt     = '0;
            need_draw_nxt = 1'b1;
          end else begin
            need_ramp_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (cmd.eye_apply) begin
      if (need_draw_r) begin
        countdown_nxt = div_quo[IVAL_W-1:0];
      end else if (phase_r == PH_CLOSING) begin
        eye_w_nxt = div_quo[WEIGHT_W-1:0];
      end else begin
        eye_w_nxt = Q16_ONE - div_quo[WEIGHT_W-1:0];
      end
    end

    if (set_req && set_ok) begin
      expr_before_nxt = expr_now_r;
      expr_now_nxt    = tgt;
      fade_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r   <= CFG_COUNT_RST;
      cfg_fade_r    <= CFG_FADE_RST;
      cfg_bdur_r    <= CFG_BDUR_RST;
      cfg_min_r     <= CFG_MIN_RST;
      cfg_max_r     <= CFG_MAX_RST;
      expr_now_r    <= '0;
      expr_before_r <= '0;
      boop_ret_r    <= '0;
      fade_r        <= Q16_ONE;
      boop_left_r   <= '0;
      phase_r       <= PH_OPEN;
      eye_t_r       <= '0;
      eye_w_r       <= '0;
      countdown_r   <= COUNTDOWN_RST;
      need_ramp_r   <= 1'b0;
      need_draw_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_EXPR_COUNT: cfg_count_r <= cfg_data[COUNT_W-1:0];
          CFG_FADE_MS:    cfg_fade_r  <= cfg_data[FADE_W-1:0];
          CFG_BLINK_DUR:  cfg_bdur_r  <= cfg_data[BDUR_W-1:0];
          CFG_IVAL_MIN:   cfg_min_r   <= cfg_data[IVAL_W-1:0];
          CFG_IVAL_MAX:   cfg_max_r   <= cfg_data[IVAL_W-1:0];
          default: ;
        endcase
      end
      expr_now_r    <= expr_now_nxt;
      expr_before_r <= expr_before_nxt;
      boop_ret_r    <= boop_ret_nxt;
      fade_r        <= fade_nxt;
      boop_left_r   <= boop_left_nxt;
      phase_r       <= phase_nxt;
      eye_t_r       <= eye_t_nxt;
      eye_w_r       <= eye_w_nxt;
      countdown_r   <= countdown_nxt;
      need_ramp_r   <= need_ramp_nxt;
      need_draw_r   <= need_draw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= operation;
      idx_r  <= expression_index;
      dur_r  <= boop_duration_ms;
      dt_r   <= elapsed_ms;
      draw_r <= random_draw;
    end
    prod_lo_r <= DIV_NUM_W'(cfg_min_r) * DIV_NUM_W'(draw_rest);
    prod_hi_r <= DIV_NUM_W'(cfg_max_r) * DIV_NUM_W'(draw_c);
    if (cmd.out_load) begin
      out_cur_r   <= expr_now_r;
      out_prev_r  <= expr_before_r;
      out_fade_r  <= fade_r;
      out_phase_r <= phase_r;
      out_eye_w_r <= eye_w_r;
      out_boop_r  <= (boop_left_r != '0);
    end
  end

  assign stat.op        = op_r;
  assign stat.fade_busy = (fade_r < Q16_ONE);
  assign stat.need_ramp = need_ramp_r;
  assign stat.need_draw = need_draw_r;

  assign current_expression  = out_cur_r;
  assign previous_expression = out_prev_r;
  assign transition_weight   = out_fade_r;
  assign blink_phase_out     = out_phase_r;
  assign blink_weight_out    = out_eye_w_r;
  assign boop_active         = out_boop_r;

endmodule

`default_nettype wire

// ----- tb/face_expression_blink_sequencer_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for face_expression_blink_sequencer.
// Needs fes_pkg, the fes_if channel interfaces and the sequencer RTL; it runs
// directed and random event traffic under several register settings.

module face_expression_blink_sequencer_test;
  import fes_pkg::*;

  // Operation codes that the package leaves unnamed. The block must treat them
  // as no-ops that still report a status.
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  // The slowest event is a tick with two divides. The settle time before
  // register writes and at the end of the run is taken above its duration.
  localparam int SETTLE_CYCLES = 48;
  // Cycles without any transfer on any channel before the run is abandoned.
  localparam int STALL_LIMIT   = 1500;
  localparam int PHASE_EVENTS  = 200;

  // One event as it is driven on the input channel.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [EXPR_W-1:0] idx;
    logic [BOOP_W-1:0] boop_ms;
    logic [DT_W-1:0]   elapsed;
    logic [DRAW_W-1:0] draw;
  } face_event_t;

  // One status report as it should appear on the result channel.
  typedef struct packed {
    logic [EXPR_W-1:0]   current;
    logic [EXPR_W-1:0]   previous;
    logic [WEIGHT_W-1:0] fade;
    logic [PHASE_W-1:0]  phase;
    logic [WEIGHT_W-1:0] lid;
    logic                boop;
  } face_status_t;

  logic clk;
  logic rst_n;

  fes_in_if  in_ch ();
  fes_out_if out_ch ();
  fes_cfg_if cfg_ch ();

  face_expression_blink_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Status reports still owed by the block, oldest first.
  face_status_t pending_status[$];
  int           fail_count  = 0;
  // When set, neither the sender nor the receiver inserts random idle gaps.
  bit           steady_flow = 1'b0;

  // ---------------------------------------------------------------------------
  // Shadow copy of the register file and of the sequencer state.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0]  reg_count;
  logic [FADE_W-1:0]   reg_fade;
  logic [BDUR_W-1:0]   reg_blink_dur;
  logic [IVAL_W-1:0]   reg_ival_min;
  logic [IVAL_W-1:0]   reg_ival_max;

  logic [EXPR_W-1:0]   shown_expr;
  logic [EXPR_W-1:0]   faded_expr;
  logic [EXPR_W-1:0]   boop_home_expr;
  logic [WEIGHT_W-1:0] fade_q16;
  logic [16:0]         boop_left;
  fes_phase_t          lid_phase;
  logic [EYE_T_W-1:0]  lid_t;
  logic [WEIGHT_W-1:0] lid_q16;
  logic [16:0]         blink_wait;

  function automatic void reset_shadow();
    reg_count      = CFG_COUNT_RST;
    reg_fade       = CFG_FADE_RST;
    reg_blink_dur  = CFG_BDUR_RST;
    reg_ival_min   = CFG_MIN_RST;
    reg_ival_max   = CFG_MAX_RST;
    shown_expr     = '0;
    faded_expr     = '0;
    boop_home_expr = '0;
    fade_q16       = Q16_ONE;
    boop_left      = '0;
    lid_phase      = PH_OPEN;
    lid_t          = '0;
    lid_q16        = '0;
    blink_wait     = 17'(COUNTDOWN_RST);
  endfunction

  // A count of zero behaves as one, and the count never exceeds the table size.
  function automatic int unsigned expr_limit();
    int unsigned n;
    n = reg_count;
    if (n == 0) n = 1;
    if (n > EXPR_CAP) n = EXPR_CAP;
    return n;
  endfunction

  // Out-of-range or already-shown targets are ignored; otherwise a new fade
  // starts from zero.
  function automatic void try_switch(int unsigned target);
    if (target >= expr_limit() || target == shown_expr) return;
    faded_expr = shown_expr;
    shown_expr = EXPR_W'(target);
    fade_q16   = '0;
  endfunction

  // Eyelid ramp: each half of the blink covers the full Q16 range.
  function automatic logic [WEIGHT_W-1:0] lid_ramp(int unsigned t);
    longint unsigned d;
    longint unsigned w;
    d = (reg_blink_dur == 0) ? 1 : reg_blink_dur;
    w = (64'(t) * 64'd131072) / d;
    return (w > Q16_ONE) ? Q16_ONE : WEIGHT_W'(w);
  endfunction

  function automatic bit ramp_finished(int unsigned t);
    int unsigned d;
    d = (reg_blink_dur == 0) ? 1 : reg_blink_dur;
    return (2 * t) >= d;
  endfunction

  // Eyelid phase time saturates instead of wrapping.
  function automatic void bump_lid_time(int unsigned dt);
    int unsigned s;
    s = lid_t + dt;
    lid_t = (s > {EYE_T_W{1'b1}}) ? {EYE_T_W{1'b1}} : EYE_T_W'(s);
  endfunction

  // Applies one accepted event to the shadow state and returns the status the
  // block must report for it.
  function automatic face_status_t advance_face(face_event_t ev);
    int unsigned  n;
    int unsigned  dt;
    int unsigned  draw;
    int unsigned  fade_div;
    int unsigned  sum;
    longint       lo;
    longint       hi;
    longint       span;
    longint       draw_span;
    face_status_t st;
    n  = expr_limit();
    dt = ev.elapsed;
    draw = ev.draw;
    case (ev.op)
      OP_TICK: begin
        // Fade first, then the boop countdown, then the eyelid machine.
        if (fade_q16 < Q16_ONE) begin
          fade_div = (reg_fade < FADE_MIN) ? FADE_MIN : reg_fade;
          sum = fade_q16 + (dt * 32'd65536) / fade_div;
          fade_q16 = (sum > Q16_ONE) ? Q16_ONE : WEIGHT_W'(sum);
        end
        if (boop_left > 0) begin
          if (dt >= boop_left) begin
            boop_left = '0;
            try_switch(boop_home_expr);
          end else begin
            boop_left = boop_left - dt;
          end
        end
        case (lid_phase)
          PH_OPEN: begin
            blink_wait = (dt >= blink_wait) ? '0 : blink_wait - dt;
            if (blink_wait == 0) begin
              lid_phase = PH_CLOSING;
              lid_t = '0;
            end
          end
          PH_CLOSING: begin
            bump_lid_time(dt);
            lid_q16 = lid_ramp(lid_t);
            if (ramp_finished(lid_t)) begin
              lid_phase = PH_HOLD;
              lid_t = '0;
            end
          end
          PH_HOLD: begin
            bump_lid_time(dt);
            if (lid_t >= HOLD_MS) begin
              lid_phase = PH_OPENING;
              lid_t = '0;
            end
          end
          default: begin
            bump_lid_time(dt);
            lid_q16 = Q16_ONE - lid_ramp(lid_t);
            if (ramp_finished(lid_t)) begin
              lid_q16   = '0;
              lid_phase = PH_OPEN;
              lid_t     = '0;
              // Next interval is interpolated between the bounds by the draw,
              // which is clamped to the span. Reversed bounds still land
              // between the two values.
              if (draw > DRAW_SPAN) draw = DRAW_SPAN;
              lo        = reg_ival_min;
              hi        = reg_ival_max;
              draw_span = DRAW_SPAN;
              span = lo * draw_span + (hi - lo) * longint'(draw);
              if (span < 0) span = 0;
              blink_wait = 17'(span / draw_span);
            end
          end
        endcase
      end
      OP_SET:  try_switch(ev.idx);
      OP_NEXT: try_switch((shown_expr + 1) % n);
      OP_PREV: try_switch((shown_expr + n - 1) % n);
      OP_BOOP: begin
        // A boop on top of a running boop keeps the original return target.
        if (boop_left == 0) boop_home_expr = shown_expr;
        boop_left = ev.boop_ms;
        try_switch(ev.idx);
      end
      OP_BLINK: begin
        if (lid_phase == PH_OPEN) begin
          lid_phase = PH_CLOSING;
          lid_t = '0;
        end
      end
      default: ;
    endcase
    st.current  = shown_expr;
    st.previous = faded_expr;
    st.fade     = fade_q16;
    st.phase    = lid_phase;
    st.lid      = lid_q16;
    st.boop     = (boop_left != 0);
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and result side.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls about a quarter of the cycles unless steady flow is on.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 25);
    end
  end

  function automatic void compare_field(string name, logic [WEIGHT_W-1:0] want_v,
                                        logic [WEIGHT_W-1:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // Every result transfer is matched against the oldest outstanding status.
  always @(posedge clk) begin : check_status
    face_status_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_status.size() == 0) begin
        $error("status transfer with no event outstanding");
        fail_count++;
      end else begin
        want = pending_status.pop_front();
        compare_field("current_expression", want.current, out_ch.current_expression);
        compare_field("previous_expression", want.previous, out_ch.previous_expression);
        compare_field("transition_weight", want.fade, out_ch.transition_weight);
        compare_field("blink_phase_out", want.phase, out_ch.blink_phase_out);
        compare_field("blink_weight_out", want.lid, out_ch.blink_weight_out);
        compare_field("boop_active", want.boop, out_ch.boop_active);
      end
    end
  end

  // The run is abandoned if no channel completes a transfer for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Event and register traffic.
  // ---------------------------------------------------------------------------

  // Drives one event and waits for its transfer. Valid stays high across
  // back-to-back events; it drops only for an idle gap or a drain of results.
  task automatic send_event(face_event_t ev);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.operation        <= ev.op;
    in_ch.expression_index <= ev.idx;
    in_ch.boop_duration_ms <= ev.boop_ms;
    in_ch.elapsed_ms       <= ev.elapsed;
    in_ch.random_draw      <= ev.draw;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_status.push_back(advance_face(ev));
  endtask

  // The sender holds off until every status owed has been received.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  // Register writes go back to back; valid is dropped by the caller.
  task automatic write_register(fes_cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_EXPR_COUNT: reg_count     = value[COUNT_W-1:0];
      CFG_FADE_MS:    reg_fade      = value[FADE_W-1:0];
      CFG_BLINK_DUR:  reg_blink_dur = value[BDUR_W-1:0];
      CFG_IVAL_MIN:   reg_ival_min  = value[IVAL_W-1:0];
      CFG_IVAL_MAX:   reg_ival_max  = value[IVAL_W-1:0];
      default: ;
    endcase
  endtask

  // Registers only change while the block is idle, so drain and settle first.
  task automatic program_registers(logic [CFG_DATA_W-1:0] count, logic [CFG_DATA_W-1:0] fade,
                                   logic [CFG_DATA_W-1:0] dur, logic [CFG_DATA_W-1:0] lo,
                                   logic [CFG_DATA_W-1:0] hi);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(CFG_EXPR_COUNT, count);
    write_register(CFG_FADE_MS, fade);
    write_register(CFG_BLINK_DUR, dur);
    write_register(CFG_IVAL_MIN, lo);
    write_register(CFG_IVAL_MAX, hi);
    cfg_ch.valid <= 1'b0;
  endtask

  // Ticks are the most common event, with modest elapsed times so fades, boops and
  // blinks run through all their phases; full-range field values are mixed in.
  function automatic face_event_t random_event();
    int unsigned pick;
    face_event_t ev;
    pick = $urandom_range(0, 99);
    if (pick < 45)      ev.op = OP_TICK;
    else if (pick < 60) ev.op = OP_SET;
    else if (pick < 70) ev.op = OP_NEXT;
    else if (pick < 80) ev.op = OP_PREV;
    else if (pick < 90) ev.op = OP_BOOP;
    else if (pick < 97) ev.op = OP_BLINK;
    else                ev.op = pick[0] ? OP_UNDEF_HI : OP_UNDEF_LO;
    ev.idx = $urandom_range(0, 15);
    pick = $urandom_range(0, 9);
    if (pick == 0)      ev.boop_ms = $urandom_range(0, 65535);
    else if (pick == 1) ev.boop_ms = '0;
    else                ev.boop_ms = $urandom_range(1, 2500);
    ev.elapsed = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 120);
    ev.draw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 10000);
    return ev;
  endfunction

  task automatic run_random_events(int count);
    repeat (count) begin
      // Now and then the sender waits for the block to empty completely.
      if ($urandom_range(0, 99) == 0) wait_results_drained();
      send_event(random_event());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests, all under the reset register values.
  // ---------------------------------------------------------------------------

  // Status straight out of reset, and the two undefined operation codes.
  task automatic test_reset_status();
    send_event('{OP_TICK, 4'd0, 16'd0, 10'd0, 14'd0});
    send_event('{OP_UNDEF_LO, 4'd15, 16'hFFFF, 10'h3FF, 14'h3FFF});
    send_event('{OP_UNDEF_HI, 4'd9, 16'd0, 10'd0, 14'd0});
  endtask

  // Set, repeated set, out-of-range index, fade growth and clamp, and
  // next/previous wrapping at both ends of the expression range.
  task automatic test_expression_steps();
    send_event('{OP_SET, 4'd3, 16'd0, 10'd0, 14'd0});
    send_event('{OP_SET, 4'd3, 16'd0, 10'd0, 14'd0});
    send_event('{OP_SET, 4'd8, 16'd0, 10'd0, 14'd0});
    send_event('{OP_SET, 4'd15, 16'd0, 10'd0, 14'd0});
    send_event('{OP_TICK, 4'd0, 16'd0, 10'd100, 14'd0});
    send_event('{OP_PREV, 4'd0, 16'd0, 10'd0, 14'd0});
    send_event('{OP_SET, 4'd0, 16'd0, 10'd0, 14'd0});
    send_event('{OP_PREV, 4'd0, 16'd0, 10'd0, 14'd0});
    send_event('{OP_NEXT, 4'd0, 16'd0, 10'd0, 14'd0});
    send_event('{OP_TICK, 4'd0, 16'd0, 10'h3FF, 14'd0});
  endtask

  // Boop saves the shown expression, a second boop keeps the saved one, a
  // zero-length boop never restores, and the countdown restores on expiry.
  task automatic test_boop_restore();
    send_event('{OP_BOOP, 4'd5, 16'd300, 10'd0, 14'd0});
    send_event('{OP_BOOP, 4'd6, 16'hFFFF, 10'd0, 14'd0});
    send_event('{OP_BOOP, 4'd2, 16'd0, 10'd0, 14'd0});
    send_event('{OP_BOOP, 4'd4, 16'd50, 10'd0, 14'd0});
    send_event('{OP_TICK, 4'd0, 16'd0, 10'd50, 14'd0});
  endtask

  // A full blink: start, ignored restart, closing ramp, hold, opening with a
  // draw above the span, then a countdown from the new interval.
  task automatic test_blink_cycle();
    send_event('{OP_BLINK, 4'd0, 16'd0, 10'd0, 14'd0});
    send_event('{OP_BLINK, 4'd0, 16'd0, 10'd0, 14'd0});
    send_event('{OP_TICK, 4'd0, 16'd0, 10'd37, 14'd0});
    send_event('{OP_TICK, 4'd0, 16'd0, 10'd38, 14'd0});
    send_event('{OP_TICK, 4'd0, 16'd0, 10'd40, 14'd0});
    send_event('{OP_TICK, 4'd0, 16'd0, 10'd1000, 14'h3FFF});
    send_event('{OP_TICK, 4'd0, 16'd0, 10'h3FF, 14'd0});
  endtask

  // ---------------------------------------------------------------------------
  // Random tests, one register setting each.
  // ---------------------------------------------------------------------------

  // Reset values written back explicitly.
  task automatic test_default_config();
    program_registers(16'd8, 16'd250, 16'd150, 16'd2000, 16'd6000);
    run_random_events(PHASE_EVENTS);
  endtask

  // All registers zero: one expression, shortest fade, shortest blink, and a
  // zero blink interval so the eyelid cycles constantly.
  task automatic test_low_extremes();
    program_registers(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random_events(PHASE_EVENTS);
  endtask

  // All data bits set: the count clamps to the table size and every other
  // register takes the top of its field.
  task automatic test_high_extremes();
    program_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random_events(PHASE_EVENTS);
  endtask

  // Minimum above maximum, with the shortest fade and a very short blink.
  task automatic test_reversed_interval();
    program_registers(16'd16, 16'd10, 16'd2, 16'd60000, 16'd0);
    run_random_events(PHASE_EVENTS);
  endtask

  // A long stretch with no random idle gaps on either side.
  task automatic test_back_to_back();
    program_registers(16'd1, 16'd10000, 16'd2000, 16'd0, 16'd60000);
    steady_flow = 1'b1;
    run_random_events(PHASE_EVENTS);
    steady_flow = 1'b0;
  endtask

  // Short intervals so blinks come often; the sender also fully drains once
  // in the middle of the traffic.
  task automatic test_frequent_blinks();
    program_registers(16'd5, 16'd37, 16'd77, 16'd100, 16'd300);
    run_random_events(PHASE_EVENTS / 2);
    wait_results_drained();
    run_random_events(PHASE_EVENTS / 2);
  endtask

  // A one-millisecond blink, so each ramp ends on its first tick with a nonzero elapsed time.
  task automatic test_instant_ramps();
    program_registers(16'd12, 16'd10, 16'd1, 16'd0, 16'd50);
    run_random_events(PHASE_EVENTS);
  endtask

  initial begin
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.operation        <= OP_TICK;
    in_ch.expression_index <= '0;
    in_ch.boop_duration_ms <= '0;
    in_ch.elapsed_ms       <= '0;
    in_ch.random_draw      <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.index           <= CFG_EXPR_COUNT;
    cfg_ch.data            <= '0;
    reset_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_status();
    test_expression_steps();
    test_boop_restore();
    test_blink_cycle();
    test_default_config();
    test_low_extremes();
    test_high_extremes();
    test_reversed_interval();
    test_back_to_back();
    test_frequent_blinks();
    test_instant_ramps();

    // Let every owed status arrive, then watch a while for stray transfers.
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
